// ===== rtl/hfrc_pkg.sv =====
// hfrc_pkg: shared types, constants and the hex decode function of the
// hex frame receive checker. No dependencies.
`timescale 1ns / 1ps

package hfrc_pkg;

  localparam int unsigned MaxFrame = 256;
  localparam int unsigned LenW     = $clog2(MaxFrame + 1);

  localparam int unsigned TokDepth = 4;
  localparam int unsigned TokPtrW  = $clog2(TokDepth);
  localparam int unsigned TokCntW  = $clog2(TokDepth + 1);

  localparam int unsigned ResDepth = 2;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  localparam logic [7:0] FrameMarkRst = 8'd58;
  localparam logic [7:0] ChLf         = 8'h0a;
  localparam logic [7:0] ChCr         = 8'h0d;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] HexAOffset   = 8'd10;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhCmd  = 2'd1,
    PhBody = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadTerm  = 3'd1,
    StOdd      = 3'd2,
    StShort    = 3'd3,
    StMismatch = 3'd4,
    StOverflow = 3'd5
  } status_e;

  // classified input word
  typedef struct packed {
    logic [7:0] raw;
    logic [3:0] nibble;
    logic       is_mark;
    logic       is_cr;
    logic       is_lf;
  } token_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data_byte;
    logic [7:0] command;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic [TokCntW-1:0] count;
  } front_stat_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c < ChUpperA) begin
      v = c - ChZero;
    end else begin
      v = c - ChUpperA + HexAOffset;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/hfrc_front.sv =====
// hfrc_front: classifies received bytes and buffers them in a token queue.
// Depends on hfrc_pkg.
`timescale 1ns / 1ps

module hfrc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          frame_mark_i,
  output logic                full_o,
  output logic                tok_valid_o,
  output hfrc_pkg::token_t    tok_o,
  input  logic                tok_pop_i,
  output hfrc_pkg::front_stat_t stat_o
);

  hfrc_pkg::token_t                 tok_mem_q [hfrc_pkg::TokDepth];
  logic [hfrc_pkg::TokPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hfrc_pkg::TokPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [hfrc_pkg::TokCntW-1:0]     count_q, count_d;
  logic                             wr_en, rd_en;
  hfrc_pkg::token_t                 tok_new;

  assign full_o      = (count_q == hfrc_pkg::TokCntW'(hfrc_pkg::TokDepth));
  assign tok_valid_o = (count_q != '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = tok_pop_i && tok_valid_o;
  assign tok_o       = tok_mem_q[rd_ptr_q];
  assign stat_o.count = count_q;

  always_comb begin
    tok_new.raw     = rx_byte_i;
    tok_new.nibble  = hfrc_pkg::hex_nibble(rx_byte_i);
    tok_new.is_mark = (rx_byte_i == frame_mark_i);
    tok_new.is_cr   = (rx_byte_i == hfrc_pkg::ChCr);
    tok_new.is_lf   = (rx_byte_i == hfrc_pkg::ChLf);
  end

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tok_mem_q[wr_ptr_q] <= tok_new;
    end
  end

endmodule

// ===== rtl/hfrc_back.sv =====
// hfrc_back: frame state machine over classified tokens, checksum and
// result queue. Depends on hfrc_pkg.
`timescale 1ns / 1ps

module hfrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  hfrc_pkg::token_t  tok_i,
  output logic              tok_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output hfrc_pkg::result_t res_o
);

  hfrc_pkg::phase_e         phase_q, phase_d;
  logic [7:0]               cmd_q, cmd_d;
  logic [7:0]               sum_q, sum_d;
  logic [3:0]               hi_q, hi_d;
  logic                     half_q, half_d;
  logic [7:0]               held_q, held_d;
  logic                     held_vld_q, held_vld_d;
  logic                     cr_q, cr_d;
  logic [hfrc_pkg::LenW-1:0] len_q, len_d;
  logic [hfrc_pkg::LenW:0]  len_inc;

  hfrc_pkg::result_t        res_mem_q [hfrc_pkg::ResDepth];
  logic [hfrc_pkg::ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [hfrc_pkg::ResCntW-1:0] count_q, count_d;
  logic                     res_full, res_pop, go;
  logic                     emit;
  hfrc_pkg::result_t        res_new;

  assign empty_o   = (count_q == '0);
  assign res_full  = (count_q == hfrc_pkg::ResCntW'(hfrc_pkg::ResDepth));
  assign res_pop   = pop_i && !empty_o;
  assign tok_pop_o = tok_valid_i && (!res_full || res_pop);
  assign go        = tok_pop_o;
  assign res_o     = res_mem_q[rd_ptr_q];
  assign len_inc   = {1'b0, len_q} + 1'b1;

  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    sum_d      = sum_q;
    hi_d       = hi_q;
    half_d     = half_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    cr_d       = cr_q;
    len_d      = len_q;
    emit       = 1'b0;
    res_new.is_end    = 1'b1;
    res_new.data_byte = '0;
    res_new.command   = cmd_q;
    res_new.status    = hfrc_pkg::StOk;
    if (go) begin
      case (phase_q)
        hfrc_pkg::PhCmd: begin
          cmd_d      = tok_i.raw;
          sum_d      = tok_i.raw;
          hi_d       = '0;
          half_d     = 1'b0;
          held_d     = '0;
          held_vld_d = 1'b0;
          cr_d       = 1'b0;
          len_d      = hfrc_pkg::LenW'(2);
          phase_d    = hfrc_pkg::PhBody;
        end
        hfrc_pkg::PhBody: begin
          if (tok_i.is_lf) begin
            if (len_q < hfrc_pkg::LenW'(hfrc_pkg::MaxFrame)) begin
              len_d = len_inc[hfrc_pkg::LenW-1:0];
            end
            emit    = 1'b1;
            phase_d = hfrc_pkg::PhHunt;
            if (!cr_q) begin
              res_new.status = hfrc_pkg::StBadTerm;
            end else if (half_q) begin
              res_new.status = hfrc_pkg::StOdd;
            end else if (!held_vld_q) begin
              res_new.status = hfrc_pkg::StShort;
            end else if (held_q != sum_q) begin
              res_new.status = hfrc_pkg::StMismatch;
            end
          end else if (cr_q) begin
            emit           = 1'b1;
            phase_d        = hfrc_pkg::PhHunt;
            res_new.status = hfrc_pkg::StBadTerm;
          end else if (len_inc >= (hfrc_pkg::LenW + 1)'(hfrc_pkg::MaxFrame)) begin
            len_d          = hfrc_pkg::LenW'(hfrc_pkg::MaxFrame);
            emit           = 1'b1;
            phase_d        = hfrc_pkg::PhHunt;
            res_new.status = hfrc_pkg::StOverflow;
          end else begin
            len_d = len_inc[hfrc_pkg::LenW-1:0];
            if (tok_i.is_cr) begin
              cr_d = 1'b1;
            end else if (!half_q) begin
              hi_d   = tok_i.nibble;
              half_d = 1'b1;
            end else begin
              half_d = 1'b0;
              if (held_vld_q) begin
                emit              = 1'b1;
                res_new.is_end    = 1'b0;
                res_new.data_byte = held_q;
                sum_d             = sum_q + held_q;
              end
              held_d     = {hi_q, tok_i.nibble};
              held_vld_d = 1'b1;
            end
          end
        end
        default: begin
          if (tok_i.is_mark) begin
            phase_d = hfrc_pkg::PhCmd;
            len_d   = hfrc_pkg::LenW'(1);
          end
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (emit && !res_pop) begin
      count_d = count_q + 1'b1;
    end else if (res_pop && !emit) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hfrc_pkg::PhHunt;
      cmd_q      <= '0;
      sum_q      <= '0;
      hi_q       <= '0;
      half_q     <= 1'b0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      cr_q       <= 1'b0;
      len_q      <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      sum_q      <= sum_d;
      hi_q       <= hi_d;
      half_q     <= half_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      cr_q       <= cr_d;
      len_q      <= len_d;
      count_q    <= count_d;
      if (emit) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (res_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_mem_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

// ===== rtl/hex_frame_receive_checker_core.sv =====
// hex_frame_receive_checker_core: top level, APB register and the front/back
// split. Depends on hfrc_pkg, hfrc_front and hfrc_back.
// Throughput: one word per cycle while the token queue is not full; the back
// stage steps one word per cycle and stalls only when its 2-entry result queue
// is full and not popped.
// Reset (rst_ni low, async): queues empty, hunting for a mark, frame_mark = 58.
`timescale 1ns / 1ps

module hex_frame_receive_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        is_end_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  command_o,
  output logic [2:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]            mark_q;
  logic                  tok_valid, tok_pop;
  hfrc_pkg::token_t      tok;
  hfrc_pkg::result_t     res;
  hfrc_pkg::front_stat_t fstat;

  assign pready = 1'b1;
  assign prdata = {24'd0, mark_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= hfrc_pkg::FrameMarkRst;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      mark_q <= pwdata[7:0];
    end
  end

  hfrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .rx_byte_i    (rx_byte_i),
    .frame_mark_i (mark_q),
    .full_o       (full),
    .tok_valid_o  (tok_valid),
    .tok_o        (tok),
    .tok_pop_i    (tok_pop),
    .stat_o       (fstat)
  );

  hfrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign is_end_o    = res.is_end;
  assign data_byte_o = res.data_byte;
  assign command_o   = res.command;
  assign status_o    = res.status;

  a_tok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= hfrc_pkg::TokCntW'(hfrc_pkg::TokDepth))
    else $error("token queue count out of range");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_end_o) |-> (status_o == hfrc_pkg::StOk))
    else $error("payload word with nonzero status");

  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_end_o) |-> (data_byte_o == 8'd0 && status_o <= hfrc_pkg::StOverflow))
    else $error("malformed end word");

endmodule
